// ----- design/fdc_pkg.sv -----
// shared constants and types of the floppy controller command engine
`timescale 1ns / 1ps

package fdc_pkg;

	localparam int BUFFER_BYTES_DEF = 256;

	localparam int FUNC_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int SLEN_W  = 9;
	localparam int REQ_W   = 2;
	localparam int UNIT_W  = 2;
	localparam int SECT_W  = 6;
	localparam int MASK_W  = 4;
	localparam int CIDX_W  = 1;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;

	localparam logic [FUNC_W-1:0] FUNC_CMD   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_DATA  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PORT  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RDONE = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_FETCH = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_WDONE = 3'd6;

	localparam logic [BYTE_W-1:0] CMD_READ_A     = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_READ_B     = 8'h07;
	localparam logic [BYTE_W-1:0] CMD_WRITE_A    = 8'h05;
	localparam logic [BYTE_W-1:0] CMD_WRITE_B    = 8'h0F;
	localparam logic [BYTE_W-1:0] CMD_CLR_A      = 8'h0B;
	localparam logic [BYTE_W-1:0] CMD_CLR_B      = 8'h81;
	localparam logic [BYTE_W-1:0] CMD_RESTORE    = 8'h0D;
	localparam logic [BYTE_W-1:0] CMD_SET_TRACK  = 8'h11;
	localparam logic [BYTE_W-1:0] CMD_SET_DENS   = 8'h15;
	localparam logic [BYTE_W-1:0] CMD_SET_UNIT   = 8'h21;
	localparam logic [BYTE_W-1:0] CMD_WBUF_ARM   = 8'h30;
	localparam logic [BYTE_W-1:0] CMD_WBUF_PUSH  = 8'h31;

	localparam int CMD_BUF_MODE_BIT = 6;

	localparam logic [BYTE_W-1:0] ST_CRC       = 8'h08;
	localparam logic [BYTE_W-1:0] ST_PROTECT   = 8'h10;
	localparam logic [BYTE_W-1:0] ST_NOT_READY = 8'h20;
	localparam logic [BYTE_W-1:0] BYTE_EMPTY   = 8'hFF;

	localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

	localparam logic [CIDX_W-1:0] REG_PRESENT = 1'd0;
	localparam logic [CIDX_W-1:0] REG_PROTECT = 1'd1;

	localparam logic [1:0] PSRC_REG  = 2'd0;
	localparam logic [1:0] PSRC_RBUF = 2'd1;
	localparam logic [1:0] PSRC_WBUF = 2'd2;

	typedef struct packed {
		logic [1:0]        src;
		logic [BYTE_W-1:0] port;
		logic [REQ_W-1:0]  req;
		logic [BYTE_W-1:0] track;
		logic [UNIT_W-1:0] unit;
		logic [SECT_W-1:0] sector;
	} fdc_res_t;

endpackage

// ----- design/fdc_ram.sv -----
// byte buffer memory with one write port and one registered read port
`timescale 1ns / 1ps

module fdc_ram #(
	parameter int DEPTH = fdc_pkg::BUFFER_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [fdc_pkg::BYTE_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [fdc_pkg::BYTE_W-1:0] rdata
);

	logic [fdc_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [fdc_pkg::BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/floppy_controller_command_engine.sv -----
// floppy controller command engine top level
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  bus access or drive transfer word
// m_*       out        m_tvalid/m_tready  port byte and sector request word
// cfg_*     in         cfg_valid/cfg_ready unit present / protect masks
//
// one word per cycle while m_* does not stall; a result passes the buffer read
// stage, then the output register, before it is valid on m_*
// all s_* register and buffer updates land on the accept edge, so a word may
// read what the word before it wrote
// arst_n resets all control and status registers (sector to 1, the rest to zero); buffers keep no reset
// a stall on m_* fills the output register then the buffer read stage
`timescale 1ns / 1ps

module floppy_controller_command_engine #(
	parameter int BUFFER_BYTES = fdc_pkg::BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// data_byte, buf_index, disk_ok, sector_length, zero fill
	input  logic [fdc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// func
	input  logic [fdc_pkg::FUNC_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// port_data, request_track, request_unit, request_sector
	output logic [fdc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// request
	output logic [fdc_pkg::REQ_W-1:0]       m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fdc_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [fdc_pkg::MASK_W-1:0]      cfg_data
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int PW = $clog2(BUFFER_BYTES + 1);
	localparam int CW = (PW > fdc_pkg::BYTE_W) ? PW : fdc_pkg::BYTE_W;
	localparam int LW = (PW > fdc_pkg::SLEN_W) ? PW : fdc_pkg::SLEN_W;

	// input word fields
	logic [fdc_pkg::FUNC_W-1:0] func;
	logic [fdc_pkg::BYTE_W-1:0] data_byte;
	logic [fdc_pkg::BYTE_W-1:0] buf_index;
	logic                       disk_ok;
	logic [fdc_pkg::SLEN_W-1:0] sector_length;

	assign func          = s_tuser;
	assign data_byte     = s_tdata[7:0];
	assign buf_index     = s_tdata[15:8];
	assign disk_ok       = s_tdata[16];
	assign sector_length = s_tdata[25:17];

	// architectural state
	logic [fdc_pkg::MASK_W-1:0] present_q, protect_q;
	logic [fdc_pkg::BYTE_W-1:0] last_cmd_q, last_data_q, track_q, density_q;
	logic [fdc_pkg::UNIT_W-1:0] unit_q;
	logic [fdc_pkg::SECT_W-1:0] sector_q;
	logic [PW-1:0]              rptr_q, rlen_q, wptr_q;
	logic                       armed_q, crc_q;

	logic [fdc_pkg::BYTE_W-1:0] last_cmd_d, last_data_d, track_d, density_d;
	logic [fdc_pkg::UNIT_W-1:0] unit_d;
	logic [fdc_pkg::SECT_W-1:0] sector_d;
	logic [PW-1:0]              rptr_d, rlen_d, wptr_d;
	logic                       armed_d, crc_d;

	// pipeline
	logic              s1_valid_q, out_valid_q, s1_move, accept;
	fdc_pkg::fdc_res_t res_d;
	fdc_pkg::fdc_res_t res_s1;
	logic [fdc_pkg::BYTE_W-1:0] out_port_q, port_fin;
	logic [fdc_pkg::REQ_W-1:0]  out_req_q;
	logic [fdc_pkg::BYTE_W-1:0] out_track_q;
	logic [fdc_pkg::UNIT_W-1:0] out_unit_q;
	logic [fdc_pkg::SECT_W-1:0] out_sector_q;

	// buffer ports
	logic                       rb_we, rb_re, wb_we, wb_re;
	logic [AW-1:0]              rb_waddr, rb_raddr, wb_waddr, wb_raddr;
	logic [fdc_pkg::BYTE_W-1:0] rb_wdata, wb_wdata, rb_rdata, wb_rdata;

	logic [CW-1:0] idx_ext;
	logic [LW-1:0] slen_ext;
	logic          idx_ok, present, protect, push;
	logic [fdc_pkg::BYTE_W-1:0] push_byte, status;

	assign s1_move   = !out_valid_q || m_tready;
	assign s_tready  = !s1_valid_q || s1_move;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign idx_ext  = CW'(buf_index);
	assign slen_ext = LW'(sector_length);
	assign idx_ok   = idx_ext < CW'(BUFFER_BYTES);
	assign present  = present_q[unit_q];
	assign protect  = protect_q[unit_q];

	always_comb begin
		status = '0;
		if (crc_q) begin
			status = status | fdc_pkg::ST_CRC;
		end
		if (!present) begin
			status = status | fdc_pkg::ST_NOT_READY;
		end else if (protect) begin
			status = status | fdc_pkg::ST_PROTECT;
		end
	end

	always_comb begin
		last_cmd_d  = last_cmd_q;
		last_data_d = last_data_q;
		track_d     = track_q;
		density_d   = density_q;
		unit_d      = unit_q;
		sector_d    = sector_q;
		rptr_d      = rptr_q;
		rlen_d      = rlen_q;
		wptr_d      = wptr_q;
		armed_d     = armed_q;
		crc_d       = crc_q;
		res_d       = '0;
		res_d.src   = fdc_pkg::PSRC_REG;
		push        = 1'b0;
		push_byte   = last_data_q;
		rb_we       = 1'b0;
		rb_re       = 1'b0;
		wb_re       = 1'b0;
		rb_waddr    = idx_ext[AW-1:0];
		rb_wdata    = data_byte;
		rb_raddr    = rptr_q[AW-1:0];
		wb_raddr    = idx_ext[AW-1:0];

		case (func)
			fdc_pkg::FUNC_CMD: begin
				last_cmd_d = data_byte;
				armed_d    = (data_byte == fdc_pkg::CMD_WBUF_ARM) ||
				             (data_byte == fdc_pkg::CMD_WBUF_PUSH);
				case (data_byte)
					fdc_pkg::CMD_READ_A, fdc_pkg::CMD_READ_B: begin
						rptr_d = '0;
						rlen_d = '0;
						crc_d  = 1'b0;
						if (present) begin
							res_d.req = fdc_pkg::REQ_READ;
						end
					end
					fdc_pkg::CMD_WRITE_A, fdc_pkg::CMD_WRITE_B: begin
						crc_d  = 1'b0;
						wptr_d = '0;
						if (present && !protect) begin
							res_d.req = fdc_pkg::REQ_WRITE;
						end
					end
					fdc_pkg::CMD_CLR_A, fdc_pkg::CMD_CLR_B: begin
						crc_d = 1'b0;
					end
					fdc_pkg::CMD_RESTORE: begin
						track_d = '0;
					end
					fdc_pkg::CMD_SET_TRACK: begin
						track_d = last_data_q;
					end
					fdc_pkg::CMD_SET_DENS: begin
						density_d = last_data_q;
					end
					fdc_pkg::CMD_SET_UNIT: begin
						unit_d   = last_data_q[7:6];
						sector_d = last_data_q[5:0];
					end
					fdc_pkg::CMD_WBUF_PUSH: begin
						push = 1'b1;
					end
					default: begin
					end
				endcase
			end
			fdc_pkg::FUNC_DATA: begin
				last_data_d = data_byte;
				push_byte   = data_byte;
				push        = armed_q;
			end
			fdc_pkg::FUNC_PORT: begin
				if (last_cmd_q[fdc_pkg::CMD_BUF_MODE_BIT]) begin
					if ((rptr_q < rlen_q) && (rptr_q < PW'(BUFFER_BYTES))) begin
						res_d.src = fdc_pkg::PSRC_RBUF;
						rb_re     = 1'b1;
						rptr_d    = rptr_q + PW'(1);
					end else begin
						res_d.port = fdc_pkg::BYTE_EMPTY;
					end
				end else begin
					res_d.port = status;
				end
			end
			fdc_pkg::FUNC_FILL: begin
				rb_we = idx_ok;
			end
			fdc_pkg::FUNC_RDONE: begin
				if (disk_ok) begin
					if (slen_ext > LW'(BUFFER_BYTES)) begin
						rlen_d = PW'(BUFFER_BYTES);
					end else begin
						rlen_d = slen_ext[PW-1:0];
					end
				end else begin
					crc_d = 1'b1;
				end
			end
			fdc_pkg::FUNC_FETCH: begin
				if (idx_ok) begin
					res_d.src = fdc_pkg::PSRC_WBUF;
					wb_re     = 1'b1;
				end
			end
			fdc_pkg::FUNC_WDONE: begin
				if (!disk_ok) begin
					crc_d = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (push && (wptr_q < PW'(BUFFER_BYTES))) begin
			wptr_d = wptr_q + PW'(1);
		end

		if (res_d.req != fdc_pkg::REQ_NONE) begin
			res_d.track  = track_q;
			res_d.unit   = unit_q;
			res_d.sector = sector_q;
		end

		rb_we = rb_we && accept;
		rb_re = rb_re && accept;
		wb_re = wb_re && accept;
	end

	assign wb_we    = accept && push && (wptr_q < PW'(BUFFER_BYTES));
	assign wb_waddr = wptr_q[AW-1:0];
	assign wb_wdata = push_byte;

	fdc_ram #(
		.DEPTH (BUFFER_BYTES),
		.AW    (AW)
	) u_rbuf (
		.clk   (clk),
		.we    (rb_we),
		.waddr (rb_waddr),
		.wdata (rb_wdata),
		.re    (rb_re),
		.raddr (rb_raddr),
		.rdata (rb_rdata)
	);

	fdc_ram #(
		.DEPTH (BUFFER_BYTES),
		.AW    (AW)
	) u_wbuf (
		.clk   (clk),
		.we    (wb_we),
		.waddr (wb_waddr),
		.wdata (wb_wdata),
		.re    (wb_re),
		.raddr (wb_raddr),
		.rdata (wb_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			protect_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fdc_pkg::REG_PRESENT: present_q <= cfg_data;
				fdc_pkg::REG_PROTECT: protect_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q  <= '0;
			last_data_q <= '0;
			track_q     <= '0;
			density_q   <= '0;
			unit_q      <= '0;
			sector_q    <= fdc_pkg::SECT_W'(1);
			rptr_q      <= '0;
			rlen_q      <= '0;
			wptr_q      <= '0;
			armed_q     <= 1'b0;
			crc_q       <= 1'b0;
		end else if (accept) begin
			last_cmd_q  <= last_cmd_d;
			last_data_q <= last_data_d;
			track_q     <= track_d;
			density_q   <= density_d;
			unit_q      <= unit_d;
			sector_q    <= sector_d;
			rptr_q      <= rptr_d;
			rlen_q      <= rlen_d;
			wptr_q      <= wptr_d;
			armed_q     <= armed_d;
			crc_q       <= crc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_d;
		end
	end

	always_comb begin
		case (res_s1.src)
			fdc_pkg::PSRC_RBUF: port_fin = rb_rdata;
			fdc_pkg::PSRC_WBUF: port_fin = wb_rdata;
			default:            port_fin = res_s1.port;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_valid_q) begin
			out_port_q   <= port_fin;
			out_req_q    <= res_s1.req;
			out_track_q  <= res_s1.track;
			out_unit_q   <= res_s1.unit;
			out_sector_q <= res_s1.sector;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_sector_q, out_unit_q, out_track_q, out_port_q};
	assign m_tuser  = out_req_q;

`ifndef SYNTHESIS
	a_wptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= PW'(BUFFER_BYTES))
		else $error("write pointer past buffer end");

	a_rptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rlen_q <= PW'(BUFFER_BYTES))
		else $error("read length past buffer end");

	a_req_no_port: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != fdc_pkg::REQ_NONE)) |-> (m_tdata[7:0] == '0))
		else $error("request word carries port byte");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !m_tready) |-> !s_tready)
		else $error("word taken while pipeline full");

	a_buf_read_once: assert property (@(posedge clk) disable iff (!arst_n)
		!(rb_re && wb_re))
		else $error("both buffers read for one word");
`endif

endmodule

// ----- dv/tb_floppy_controller_command_engine.sv -----
// self-checking testbench of the floppy controller command engine
`timescale 1ns / 1ps

module tb_floppy_controller_command_engine;

	localparam int                         BUF_BYTES   = fdc_pkg::BUFFER_BYTES_DEF;
	localparam int                         IDLE_LIMIT  = 2000;
	localparam int                         SETTLE      = 8;
	localparam int                         PHASE_OPS   = 50;
	localparam logic [fdc_pkg::FUNC_W-1:0] FUNC_UNUSED = 3'd7;

	typedef struct packed {
		logic [fdc_pkg::FUNC_W-1:0] func;
		logic [fdc_pkg::BYTE_W-1:0] data;
		logic [fdc_pkg::BYTE_W-1:0] idx;
		logic                       ok;
		logic [fdc_pkg::SLEN_W-1:0] slen;
	} bus_word_t;

	typedef struct packed {
		logic [fdc_pkg::BYTE_W-1:0] port;
		logic [fdc_pkg::REQ_W-1:0]  req;
		logic [fdc_pkg::BYTE_W-1:0] track;
		logic [fdc_pkg::UNIT_W-1:0] unit;
		logic [fdc_pkg::SECT_W-1:0] sector;
	} drive_resp_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [fdc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [fdc_pkg::FUNC_W-1:0]      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [fdc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [fdc_pkg::REQ_W-1:0]       m_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [fdc_pkg::CIDX_W-1:0]      cfg_index = '0;
	logic [fdc_pkg::MASK_W-1:0]      cfg_data = '0;

	floppy_controller_command_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// engine shadow state
	logic [fdc_pkg::MASK_W-1:0] present_mask, protect_mask;
	logic [fdc_pkg::BYTE_W-1:0] cmd_reg, data_reg, trk_reg, dens_reg;
	logic [fdc_pkg::UNIT_W-1:0] unit_sel;
	logic [fdc_pkg::SECT_W-1:0] sect_reg;
	logic [fdc_pkg::BYTE_W-1:0] rbuf [BUF_BYTES];
	logic [fdc_pkg::BYTE_W-1:0] wbuf [BUF_BYTES];
	logic [fdc_pkg::SLEN_W-1:0] rptr, rlen, wptr;
	logic                       wbuf_armed, crc_flag;

	bus_word_t   bus_ops [$];
	drive_resp_t pending_replies [$];
	bus_word_t   cur_op;
	int          ops_made = 0;
	int          mismatches = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	int          idle_cycles = 0;
	int          stall_span = 0;
	int          stall_mode = 0;
	logic [15:0] stall_bits = '0;

	function automatic void push_wbuf(logic [fdc_pkg::BYTE_W-1:0] b);
		if (wptr < BUF_BYTES) begin
			wbuf[wptr[7:0]] = b;
			wptr = wptr + 1'b1;
		end
	endfunction

	function automatic drive_resp_t engine_response(bus_word_t w);
		drive_resp_t r;
		logic        present, prot;
		r = '0;
		present = present_mask[unit_sel];
		prot = protect_mask[unit_sel];
		case (w.func)
		fdc_pkg::FUNC_CMD: begin
			cmd_reg = w.data;
			case (w.data)
			fdc_pkg::CMD_READ_A, fdc_pkg::CMD_READ_B: begin
				rptr = '0;
				rlen = '0;
				crc_flag = 1'b0;
				if (present) r.req = fdc_pkg::REQ_READ;
			end
			fdc_pkg::CMD_WRITE_A, fdc_pkg::CMD_WRITE_B: begin
				crc_flag = 1'b0;
				if (present && !prot) r.req = fdc_pkg::REQ_WRITE;
				wptr = '0;
			end
			fdc_pkg::CMD_CLR_A, fdc_pkg::CMD_CLR_B: crc_flag = 1'b0;
			fdc_pkg::CMD_RESTORE: trk_reg = '0;
			fdc_pkg::CMD_SET_TRACK: trk_reg = data_reg;
			fdc_pkg::CMD_SET_DENS: dens_reg = data_reg;
			fdc_pkg::CMD_SET_UNIT: begin
				unit_sel = data_reg[7:6];
				sect_reg = data_reg[5:0];
			end
			fdc_pkg::CMD_WBUF_PUSH: push_wbuf(data_reg);
			default: ;
			endcase
			wbuf_armed = (w.data == fdc_pkg::CMD_WBUF_ARM) ||
				(w.data == fdc_pkg::CMD_WBUF_PUSH);
		end
		fdc_pkg::FUNC_DATA: begin
			data_reg = w.data;
			if (wbuf_armed) push_wbuf(w.data);
		end
		fdc_pkg::FUNC_PORT: begin
			if (cmd_reg[fdc_pkg::CMD_BUF_MODE_BIT]) begin
				if (rptr < rlen && rptr < BUF_BYTES) begin
					r.port = rbuf[rptr[7:0]];
					rptr = rptr + 1'b1;
				end else begin
					r.port = fdc_pkg::BYTE_EMPTY;
				end
			end else begin
				if (crc_flag) r.port = r.port | fdc_pkg::ST_CRC;
				if (!present) r.port = r.port | fdc_pkg::ST_NOT_READY;
				else if (prot) r.port = r.port | fdc_pkg::ST_PROTECT;
			end
		end
		fdc_pkg::FUNC_FILL: begin
			if (w.idx < BUF_BYTES) rbuf[w.idx] = w.data;
		end
		fdc_pkg::FUNC_RDONE: begin
			if (w.ok) rlen = (w.slen > BUF_BYTES) ? fdc_pkg::SLEN_W'(BUF_BYTES) : w.slen;
			else crc_flag = 1'b1;
		end
		fdc_pkg::FUNC_FETCH: begin
			if (w.idx < BUF_BYTES) r.port = wbuf[w.idx];
		end
		fdc_pkg::FUNC_WDONE: begin
			if (!w.ok) crc_flag = 1'b1;
		end
		default: ;
		endcase
		if (r.req != fdc_pkg::REQ_NONE) begin
			r.track = trk_reg;
			r.unit = unit_sel;
			r.sector = sect_reg;
		end
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [fdc_pkg::BYTE_W-1:0] rnd_byte();
		return fdc_pkg::BYTE_W'($urandom);
	endfunction

	function automatic logic [fdc_pkg::SLEN_W-1:0] rnd_len();
		case ($urandom_range(0, 3))
		0: return 9'd128;
		1: return 9'd256;
		2: return fdc_pkg::SLEN_W'($urandom_range(0, 8));
		default: return fdc_pkg::SLEN_W'($urandom_range(0, 256));
		endcase
	endfunction

	task automatic put(input logic [fdc_pkg::FUNC_W-1:0] f,
			input logic [fdc_pkg::BYTE_W-1:0] d,
			input logic [fdc_pkg::BYTE_W-1:0] ix, input logic ok,
			input logic [fdc_pkg::SLEN_W-1:0] sl);
		bus_word_t w;
		w.func = f;
		w.data = d;
		w.idx = ix;
		w.ok = ok;
		w.slen = sl;
		bus_ops.insert(bus_ops.size(), w);
		ops_made++;
	endtask

	task automatic put_op(input logic [fdc_pkg::FUNC_W-1:0] f,
			input logic [fdc_pkg::BYTE_W-1:0] d);
		put(f, d, rnd_byte(), 1'($urandom), rnd_len());
	endtask

	task automatic write_reg(input logic [fdc_pkg::CIDX_W-1:0] ix,
			input logic [fdc_pkg::MASK_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (ix == fdc_pkg::REG_PRESENT) present_mask = v;
		else protect_mask = v;
	endtask

	task automatic set_masks(input logic [fdc_pkg::MASK_W-1:0] pres,
			input logic [fdc_pkg::MASK_W-1:0] prot);
		write_reg(fdc_pkg::REG_PRESENT, pres);
		write_reg(fdc_pkg::REG_PROTECT, prot);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (bus_ops.size() != 0 || s_tvalid || pending_replies.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int start;
		start = ops_made;
		while (ops_made - start < n) begin
			case ($urandom_range(0, 9))
			0, 1, 2: begin
				if ($urandom_range(0, 2) == 0) begin
					put_op(fdc_pkg::FUNC_DATA, rnd_byte());
					put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_UNIT);
				end
				put_op(fdc_pkg::FUNC_CMD,
					$urandom_range(0, 1) ? fdc_pkg::CMD_READ_A : fdc_pkg::CMD_READ_B);
				repeat ($urandom_range(0, 6)) put_op(fdc_pkg::FUNC_FILL, rnd_byte());
				put(fdc_pkg::FUNC_RDONE, rnd_byte(), rnd_byte(), $urandom_range(0, 7) != 0,
					rnd_len());
				put_op(fdc_pkg::FUNC_CMD, rnd_byte() | 8'h40);
				repeat ($urandom_range(1, 8)) put_op(fdc_pkg::FUNC_PORT, rnd_byte());
			end
			3, 4: begin
				put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WBUF_ARM);
				repeat ($urandom_range(0, 6)) put_op(fdc_pkg::FUNC_DATA, rnd_byte());
				if ($urandom_range(0, 1)) put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WBUF_PUSH);
				put_op(fdc_pkg::FUNC_CMD,
					$urandom_range(0, 1) ? fdc_pkg::CMD_WRITE_A : fdc_pkg::CMD_WRITE_B);
				repeat ($urandom_range(0, 4)) put_op(fdc_pkg::FUNC_FETCH, rnd_byte());
				put(fdc_pkg::FUNC_WDONE, rnd_byte(), rnd_byte(), $urandom_range(0, 7) != 0,
					rnd_len());
			end
			5: begin
				put_op(fdc_pkg::FUNC_DATA, rnd_byte());
				case ($urandom_range(0, 3))
				0: put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_TRACK);
				1: put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_DENS);
				2: put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_UNIT);
				default: put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_RESTORE);
				endcase
			end
			6: begin
				case ($urandom_range(0, 2))
				0: put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_CLR_A);
				1: put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_CLR_B);
				default: put_op(fdc_pkg::FUNC_CMD, rnd_byte() & 8'hBF);
				endcase
				repeat ($urandom_range(1, 3)) put_op(fdc_pkg::FUNC_PORT, rnd_byte());
			end
			7: begin
				put_op($urandom_range(0, 1) ? fdc_pkg::FUNC_RDONE : fdc_pkg::FUNC_WDONE,
					rnd_byte());
			end
			default: begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 49) == 0) put_op(FUNC_UNUSED, rnd_byte());
					else put_op(fdc_pkg::FUNC_W'($urandom_range(0, 6)), rnd_byte());
				end
			end
			endcase
		end
	endtask

	// sender: bursts of words with random gaps
	always @(posedge clk) begin
		bus_word_t nxt;
		logic      taken;
		if (arst_n) begin
			taken = s_tvalid && s_tready;
			if (taken) pending_replies.insert(pending_replies.size(), engine_response(cur_op));
			if (!s_tvalid || taken) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (bus_ops.size() != 0) begin
					nxt = bus_ops.pop_front();
					cur_op <= nxt;
					s_tdata <= {6'd0, nxt.slen, nxt.ok, nxt.idx, nxt.data};
					s_tuser <= nxt.func;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_bits <= 16'($urandom);
			stall_span <= $urandom_range(16, 96);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= 1'($urandom);
		2: m_tready <= stall_bits[stall_span[3:0]];
		default: m_tready <= $urandom_range(0, 7) != 0;
		endcase
	end

	always @(posedge clk) begin
		drive_resp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("result word with nothing pending: tuser 0x%0h tdata 0x%0h",
					m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				check_field("port_data", want.port, m_tdata[7:0]);
				check_field("request", want.req, m_tuser);
				check_field("request_track", want.track, m_tdata[15:8]);
				check_field("request_unit", want.unit, m_tdata[17:16]);
				check_field("request_sector", want.sector, m_tdata[23:18]);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		present_mask = '0;
		protect_mask = '0;
		cmd_reg = '0;
		data_reg = '0;
		trk_reg = '0;
		dens_reg = '0;
		unit_sel = '0;
		sect_reg = 6'd1;
		rptr = '0;
		rlen = '0;
		wptr = '0;
		wbuf_armed = 1'b0;
		crc_flag = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// units 0-2 mounted, unit 1 protected
		set_masks(4'b0111, 4'b0010);
		put_op(fdc_pkg::FUNC_PORT, rnd_byte());
		put_op(fdc_pkg::FUNC_DATA, 8'h7F);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_UNIT);
		put_op(fdc_pkg::FUNC_PORT, rnd_byte());
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WRITE_A);
		put_op(fdc_pkg::FUNC_DATA, 8'hFF);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_TRACK);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_DENS);
		put_op(fdc_pkg::FUNC_DATA, 8'h80);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_UNIT);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_READ_A);
		put(fdc_pkg::FUNC_FILL, 8'h00, 8'd0, 1'b0, 9'd0);
		put(fdc_pkg::FUNC_FILL, 8'hA5, 8'd1, 1'b1, 9'd511 & 9'd256);
		put(fdc_pkg::FUNC_RDONE, rnd_byte(), rnd_byte(), 1'b0, 9'd128);
		put(fdc_pkg::FUNC_RDONE, rnd_byte(), rnd_byte(), 1'b1, 9'd2);
		put_op(fdc_pkg::FUNC_CMD, 8'h40);
		repeat (3) put_op(fdc_pkg::FUNC_PORT, rnd_byte());
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WBUF_ARM);
		put_op(fdc_pkg::FUNC_DATA, 8'h12);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WBUF_PUSH);
		put(fdc_pkg::FUNC_FETCH, rnd_byte(), 8'd1, 1'b1, 9'd255);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WRITE_B);
		put(fdc_pkg::FUNC_WDONE, rnd_byte(), rnd_byte(), 1'b0, 9'd0);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_CLR_A);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_CLR_B);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_RESTORE);
		put_op(FUNC_UNUSED, 8'hFF);
		put(fdc_pkg::FUNC_RDONE, rnd_byte(), rnd_byte(), 1'b1, 9'd256);
		put_op(fdc_pkg::FUNC_DATA, 8'hC0);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_SET_UNIT);
		put_op(fdc_pkg::FUNC_PORT, rnd_byte());
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_READ_B);
		drain();

		// whole sectors first so every buffer byte holds known data
		set_masks(4'hF, 4'h0);
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_READ_A);
		for (int i = 0; i < BUF_BYTES; i++) begin
			put(fdc_pkg::FUNC_FILL, rnd_byte(), fdc_pkg::BYTE_W'(i), 1'($urandom), rnd_len());
		end
		put(fdc_pkg::FUNC_RDONE, rnd_byte(), rnd_byte(), 1'b1, 9'd256);
		put_op(fdc_pkg::FUNC_CMD, 8'h40);
		repeat (8) put_op(fdc_pkg::FUNC_PORT, rnd_byte());
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WBUF_ARM);
		repeat (BUF_BYTES + 2) put_op(fdc_pkg::FUNC_DATA, rnd_byte());
		repeat (4) put_op(fdc_pkg::FUNC_FETCH, rnd_byte());
		put_op(fdc_pkg::FUNC_CMD, fdc_pkg::CMD_WRITE_A);
		put(fdc_pkg::FUNC_WDONE, rnd_byte(), rnd_byte(), 1'b1, 9'd128);
		random_phase(PHASE_OPS);
		drain();

		set_masks(4'hF, 4'hF);
		random_phase(PHASE_OPS);
		drain();

		set_masks(4'h0, 4'hF);
		random_phase(PHASE_OPS);
		drain();

		set_masks(fdc_pkg::MASK_W'($urandom), fdc_pkg::MASK_W'($urandom));
		random_phase(PHASE_OPS);
		drain();

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
